[hw/rtl/sorted_region_range_table_core_assert.svh]
// Assertion macros for the sorted region range table.
// Each macro expects clk and rst_n in scope.
`ifndef SORTED_REGION_RANGE_TABLE_CORE_ASSERT_SVH
`define SORTED_REGION_RANGE_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srrt: same-cycle check failed");
`define SRRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srrt: next-cycle check failed");
`else
`define SRRT_ASSERT_IMP(label, ante, cons)
`define SRRT_ASSERT_NXT(label, ante, cons)
`endif

`endif

[hw/rtl/srrt_pkg.sv]
`default_nettype none

package srrt_pkg;

    localparam int DEFAULT_DEPTH = 32;

    typedef logic [1:0] op_t;
    localparam op_t OP_CLEAR  = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
        logic [3:0]  kind;
        logic [7:0]  flags;
    } entry_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] pos;
        entry_t     entry;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_region_range_table_core.sv]
// Sorted region range table.
// Input channel (in_valid/in_ready) takes one op beat: clear, insert or look up.
// Output channel (out_valid/out_ready) returns exactly one result beat per op.
// All entries live in one single-port-write, registered-read table memory;
// a small sequencer walks it one entry per cycle through the compare logic.
// Handling from input beat to result:
//   clear, unused op, full-table insert, insert or lookup on empty table:
//   result set from the beat with no table walk.
//   insert: the walk runs from the top entry down, shifting each entry up
//   by one until the insert slot is found.
//   lookup: the walk runs from entry 0 upward and stops on the first
//   match.
// One op is in progress at a time; in_ready is high only when the sequencer
// is idle. A finished result sits in the output register, so a new beat is
// taken while the receiver stalls; if the next result is done before the
// output register frees, the sequencer holds it and stays busy.
// Reset empties the table (entry count to zero) and drops any pending
// result; no clearing pass is needed since only stored entries are read.
`default_nettype none

`include "sorted_region_range_table_core_assert.svh"

module sorted_region_range_table_core #(
    parameter int TABLE_DEPTH = srrt_pkg::DEFAULT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] region_base,
    input  wire logic [63:0] region_size,
    input  wire logic [3:0]  region_kind,
    input  wire logic [7:0]  region_flags,
    input  wire logic [63:0] query_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [4:0]       hit_position,
    output logic [63:0]      hit_base,
    output logic [63:0]      hit_size,
    output logic [3:0]       hit_kind,
    output logic [7:0]       hit_flags
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;  // walk down, shift entries up
    localparam logic [2:0] S_PLACE = 3'd2;  // new entry goes to slot 0
    localparam logic [2:0] S_LOOK  = 3'd3;  // walk up, compare range
    localparam logic [2:0] S_DONE  = 3'd4;  // result waits for output reg

    // Low 5 bits of a table position.
    function automatic logic [4:0] pos5(input logic [CNT_W-1:0] p);
        logic [CNT_W+4:0] w;
        w = {5'b0, p};
        return w[4:0];
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    srrt_pkg::entry_t      new_reg, new_next;
    logic [63:0]           addr_reg, addr_next;
    srrt_pkg::result_t     res_reg, res_next;
    srrt_pkg::result_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    // Table memory
    srrt_pkg::entry_t      mem [TABLE_DEPTH];
    srrt_pkg::entry_t      rd_data_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    srrt_pkg::entry_t      wr_data;

    srrt_pkg::entry_t      entry_in;
    logic [CNT_W-1:0]      count_m1;
    logic [CNT_W-1:0]      idx_ext;
    logic [CNT_W-1:0]      idx_p1;
    logic [63:0]           look_end;
    logic                  look_hit;
    logic                  moves;
    logic                  out_free;

    assign entry_in = '{base: region_base, size: region_size,
                        kind: region_kind, flags: region_flags};
    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_ext  = CNT_W'(idx_reg);
    assign idx_p1   = idx_ext + CNT_W'(1);

    // Compare logic on the read entry: range check for lookup, base order for insert.
    assign look_end = rd_data_reg.base + rd_data_reg.size;
    assign look_hit = (addr_reg >= rd_data_reg.base) && (addr_reg < look_end);
    // Slot 0 stays put on an equal base; later slots move on equal base.
    assign moves = (idx_reg == '0) ? (rd_data_reg.base > new_reg.base)
                                   : (rd_data_reg.base >= new_reg.base);

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = new_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next   = entry_in;
                    addr_next  = query_addr;
                    res_next   = '0;
                    state_next = S_DONE;
                    case (op)
                        srrt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        srrt_pkg::OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = srrt_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = '0;
                                wr_data        = entry_in;
                                count_next     = CNT_W'(1);
                                res_next.entry = entry_in;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = count_m1[IDX_W-1:0];
                                idx_next   = count_m1[IDX_W-1:0];
                                state_next = S_INS;
                            end
                        end
                        srrt_pkg::OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = srrt_pkg::ST_MISS;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                if (moves)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_p1[IDX_W-1:0];
                    wr_data = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - IDX_W'(1);
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_p1[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    res_next   = '{status: srrt_pkg::ST_OK, pos: pos5(idx_p1),
                                   entry: new_reg};
                    state_next = S_DONE;
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = count_reg + CNT_W'(1);
                res_next   = '{status: srrt_pkg::ST_OK, pos: 5'd0, entry: new_reg};
                state_next = S_DONE;
            end
            S_LOOK:
            begin
                if (look_hit)
                begin
                    res_next   = '{status: srrt_pkg::ST_OK, pos: pos5(idx_ext),
                                   entry: rd_data_reg};
                    state_next = S_DONE;
                end
                else if (idx_p1 == count_reg)
                begin
                    res_next        = '0;
                    res_next.status = srrt_pkg::ST_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[IDX_W-1:0];
                    idx_next = idx_p1[IDX_W-1:0];
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        new_reg  <= new_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign hit_position = out_reg.pos;
    assign hit_base     = out_reg.entry.base;
    assign hit_size     = out_reg.entry.size;
    assign hit_kind     = out_reg.entry.kind;
    assign hit_flags    = out_reg.entry.flags;

    `SRRT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `SRRT_ASSERT_NXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
    `SRRT_ASSERT_IMP(a_walk_in_range, state_reg == S_INS || state_reg == S_LOOK, idx_ext < count_reg)
    `SRRT_ASSERT_IMP(a_full_only_when_full, state_reg == S_DONE && res_reg.status == srrt_pkg::ST_FULL, count_reg == CNT_W'(TABLE_DEPTH))

endmodule

`default_nettype wire
